// File: rtl/wnrl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wnrl_pkg;

  // table depth default
  localparam int DEF_DEPTH = 1024;

  // field widths
  localparam int TIME_W  = 32;
  localparam int POS_W   = 27;
  localparam int LOSS_W  = 16;
  localparam int PATHS_W = 16;
  localparam int COMP_W  = 32;
  localparam int WGT_W   = 16;
  localparam int IDX_W   = 10;

  // accumulator widths
  localparam int SP_W   = 57;
  localparam int DT2_W  = 64;
  localparam int DIST_W = 82;

  // opcodes
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  // register indexes
  localparam logic REG_TIME_WEIGHT  = 1'b0;
  localparam logic REG_SPACE_WEIGHT = 1'b1;

  // sequencer steps within one record
  localparam logic [3:0] STEP_DT     = 4'd6;
  localparam logic [3:0] STEP_SP_LO  = 4'd7;
  localparam logic [3:0] STEP_SP_HI  = 4'd8;
  localparam logic [3:0] STEP_DT_LO  = 4'd9;
  localparam logic [3:0] STEP_DT_HI  = 4'd10;
  localparam logic [3:0] STEP_LAST_ACC = 4'd11;
  localparam logic [3:0] STEP_CMP    = 4'd12;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FETCH
  } st_t;

  typedef struct packed {
    logic [TIME_W-1:0]         tm;
    logic signed [POS_W-1:0]   sx;
    logic signed [POS_W-1:0]   sy;
    logic signed [POS_W-1:0]   sz;
    logic signed [POS_W-1:0]   ux;
    logic signed [POS_W-1:0]   uy;
    logic signed [POS_W-1:0]   uz;
    logic [LOSS_W-1:0]         loss;
    logic [PATHS_W-1:0]        paths;
    logic [COMP_W-1:0]         comp;
  } rec_t;

  localparam int REC_W = TIME_W + 6 * POS_W + LOSS_W + PATHS_W + COMP_W;

endpackage

`default_nettype wire

// File: rtl/wnrl_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module wnrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                clk,
  input  wire logic                                we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                    wdata,
  input  wire logic                                re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                    rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/weighted_nearest_record_lookup.sv
`timescale 1ns / 1ps
`default_nettype none

// weighted nearest record lookup
// requests arrive on start/in_* and are taken when start is high and busy is low.
// opcode clear, append and unused codes answer in the cycle after the request;
// busy stays low, so a new request may follow at once.
// a query on a filled table scans every stored record with one shared 32x32
// multiplier, taking for each record six squared position differences, the
// squared time difference, four partial weight products, final add and compare,
// then fetches the winner from the table; busy is high meanwhile.
// a query on an empty table answers in the cycle after the request.
// each answer sits on out_* for exactly one cycle, marked by out_valid; the
// receiver cannot stall, so it must take it then.
// the weights are written through the apb port (time weight at 0x0, space
// weight at 0x4); the user must write them only while the block is idle, as the block does not enforce it.
// synchronous reset empties the table and sets both weights to 256 (1.0);
// record storage itself is not cleared and needs no clearing pass.
module weighted_nearest_record_lookup
  import wnrl_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_DEPTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // request channel
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [1:0]                 in_opcode,
  input  wire logic [TIME_W-1:0]          in_time_ms,
  input  wire logic signed [POS_W-1:0]    in_sat_x,
  input  wire logic signed [POS_W-1:0]    in_sat_y,
  input  wire logic signed [POS_W-1:0]    in_sat_z,
  input  wire logic signed [POS_W-1:0]    in_ue_x,
  input  wire logic signed [POS_W-1:0]    in_ue_y,
  input  wire logic signed [POS_W-1:0]    in_ue_z,
  input  wire logic [LOSS_W-1:0]          in_loss_in,
  input  wire logic [PATHS_W-1:0]         in_paths_in,
  input  wire logic [COMP_W-1:0]          in_compute_in,
  // result channel
  output logic                            out_valid,
  output logic                            out_ok,
  output logic [IDX_W-1:0]                out_match_index,
  output logic [LOSS_W-1:0]               out_loss_out,
  output logic [PATHS_W-1:0]              out_paths_out,
  output logic [COMP_W-1:0]               out_compute_out,
  // configuration port
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [2:0]                 paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // control registers
  st_t              state_r, state_nxt;
  logic [3:0]       step_r, step_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [WGT_W-1:0] wt_r, ws_r;
  logic             out_valid_r, out_valid_nxt;

  // datapath registers
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [AW-1:0]     best_r, best_nxt;
  logic [DIST_W-1:0] best_d_r, best_d_nxt;
  logic [SP_W-1:0]   sp_r, sp_nxt;
  logic [DT2_W-1:0]  dt2_r, dt2_nxt;
  logic [DIST_W-1:0] d_r, d_nxt;
  logic [63:0]       prod_r, prod_nxt;
  rec_t              q_r, q_nxt;
  logic              ok_r, ok_nxt;
  logic [IDX_W-1:0]  midx_r, midx_nxt;
  logic [LOSS_W-1:0] loss_r, loss_nxt;
  logic [PATHS_W-1:0] paths_r, paths_nxt;
  logic [COMP_W-1:0] comp_r, comp_nxt;

  // memory port
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [REC_W-1:0]  ram_rdata;
  rec_t              rec, wrec;

  // shared unit operands
  logic signed [POS_W-1:0] pa, pb;
  logic signed [POS_W:0]   pdiff;
  logic [POS_W:0]          pabs;
  logic [TIME_W-1:0]       dt;
  logic [31:0]             mul_a, mul_b;

  logic              accept, cfg_we, better, last;
  logic [AW:0]       idx_inc;
  logic [AW+IDX_W-1:0] best_wide;

  assign accept = start && !busy;
  assign cfg_we = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SPACE_WEIGHT) ? {16'b0, ws_r} : {16'b0, wt_r};

  assign rec = rec_t'(ram_rdata);

  // record to append
  always_comb begin
    wrec.tm    = in_time_ms;
    wrec.sx    = in_sat_x;
    wrec.sy    = in_sat_y;
    wrec.sz    = in_sat_z;
    wrec.ux    = in_ue_x;
    wrec.uy    = in_ue_y;
    wrec.uz    = in_ue_z;
    wrec.loss  = in_loss_in;
    wrec.paths = in_paths_in;
    wrec.comp  = in_compute_in;
  end

  wnrl_ram #(
    .WIDTH (REC_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata (wrec),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // coordinate pair for the current squaring step
  always_comb begin
    unique case (step_r)
      4'd0:    begin pa = rec.sx; pb = q_r.sx; end
      4'd1:    begin pa = rec.sy; pb = q_r.sy; end
      4'd2:    begin pa = rec.sz; pb = q_r.sz; end
      4'd3:    begin pa = rec.ux; pb = q_r.ux; end
      4'd4:    begin pa = rec.uy; pb = q_r.uy; end
      default: begin pa = rec.uz; pb = q_r.uz; end
    endcase
  end

  assign pdiff = {pa[POS_W-1], pa} - {pb[POS_W-1], pb};
  assign pabs  = pdiff[POS_W] ? (POS_W+1)'(-pdiff) : pdiff;
  assign dt    = (rec.tm >= q_r.tm) ? (rec.tm - q_r.tm) : (q_r.tm - rec.tm);

  // operand select for the shared multiplier
  always_comb begin
    unique case (step_r)
      4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5: begin
        mul_a = 32'(pabs);
        mul_b = 32'(pabs);
      end
      STEP_DT:    begin mul_a = dt;               mul_b = dt; end
      STEP_SP_LO: begin mul_a = sp_r[31:0];       mul_b = 32'(ws_r); end
      STEP_SP_HI: begin mul_a = 32'(sp_r[SP_W-1:32]); mul_b = 32'(ws_r); end
      STEP_DT_LO: begin mul_a = dt2_r[31:0];      mul_b = 32'(wt_r); end
      STEP_DT_HI: begin mul_a = dt2_r[63:32];     mul_b = 32'(wt_r); end
      default:    begin mul_a = 32'b0;            mul_b = 32'b0; end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  // compare and advance at the end of a record
  assign better    = (idx_r == '0) || (d_r < best_d_r);
  assign idx_inc   = (AW+1)'(idx_r) + (AW+1)'(1);
  assign last      = idx_inc >= (AW+1)'(count_r);
  assign best_wide = (AW+IDX_W)'(best_r);

  // sequencer: next state, accumulators and results
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    idx_nxt       = idx_r;
    best_nxt      = best_r;
    best_d_nxt    = best_d_r;
    sp_nxt        = sp_r;
    dt2_nxt       = dt2_r;
    d_nxt         = d_r;
    q_nxt         = q_r;
    ok_nxt        = 1'b0;
    midx_nxt      = '0;
    loss_nxt      = '0;
    paths_nxt     = '0;
    comp_nxt      = '0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = '0;
    busy          = 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          unique case (in_opcode)
            OP_CLEAR: begin
              count_nxt     = '0;
              ok_nxt        = 1'b1;
              out_valid_nxt = 1'b1;
            end
            OP_APPEND: begin
              out_valid_nxt = 1'b1;
              if (count_r < CW'(TABLE_DEPTH)) begin
                ram_we    = 1'b1;
                count_nxt = count_r + CW'(1);
                ok_nxt    = 1'b1;
              end
            end
            OP_QUERY: begin
              if (count_r == '0) begin
                loss_nxt      = '1;
                out_valid_nxt = 1'b1;
              end else begin
                q_nxt     = wrec;
                ram_re    = 1'b1;
                idx_nxt   = '0;
                step_nxt  = '0;
                state_nxt = ST_SCAN;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      ST_SCAN: begin
        step_nxt = step_r + 4'd1;
        // fold in the product of the previous step
        unique case (step_r)
          4'd1:                   sp_nxt  = SP_W'(prod_r);
          4'd2, 4'd3, 4'd4, 4'd5,
          STEP_DT:                sp_nxt  = sp_r + SP_W'(prod_r);
          STEP_SP_LO:             dt2_nxt = prod_r;
          STEP_SP_HI:             d_nxt   = DIST_W'(prod_r);
          STEP_DT_LO, STEP_LAST_ACC: d_nxt = d_r + (DIST_W'(prod_r) << 32);
          STEP_DT_HI:             d_nxt   = d_r + DIST_W'(prod_r);
          default: ;
        endcase
        if (step_r == STEP_CMP) begin
          if (better) begin
            best_nxt   = idx_r;
            best_d_nxt = d_r;
          end
          step_nxt = '0;
          ram_re   = 1'b1;
          if (last) begin
            ram_raddr = better ? idx_r : best_r;
            state_nxt = ST_FETCH;
          end else begin
            idx_nxt   = idx_inc[AW-1:0];
            ram_raddr = idx_inc[AW-1:0];
          end
        end
      end

      ST_FETCH: begin
        ok_nxt        = 1'b1;
        midx_nxt      = best_wide[IDX_W-1:0];
        loss_nxt      = rec.loss;
        paths_nxt     = rec.paths;
        comp_nxt      = rec.comp;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control registers and weights
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      wt_r        <= WGT_W'(256);
      ws_r        <= WGT_W'(256);
    end else begin
      step_r      <= step_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        if (paddr[2] == REG_TIME_WEIGHT) begin
          wt_r <= pwdata[WGT_W-1:0];
        end else begin
          ws_r <= pwdata[WGT_W-1:0];
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    best_r   <= best_nxt;
    best_d_r <= best_d_nxt;
    sp_r     <= sp_nxt;
    dt2_r    <= dt2_nxt;
    d_r      <= d_nxt;
    prod_r   <= prod_nxt;
    q_r      <= q_nxt;
    ok_r     <= ok_nxt;
    midx_r   <= midx_nxt;
    loss_r   <= loss_nxt;
    paths_r  <= paths_nxt;
    comp_r   <= comp_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = ok_r;
  assign out_match_index = midx_r;
  assign out_loss_out    = loss_r;
  assign out_paths_out   = paths_r;
  assign out_compute_out = comp_r;

  // checks
  a_no_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && busy))
    else $error("result strobed while a query is running");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH))
    else $error("record count beyond table depth");

  a_quick_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_opcode != OP_QUERY) |=> (out_valid && !busy))
    else $error("non-query request not answered next cycle");

  a_fail_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_match_index == '0))
    else $error("failed request carries a match index");

endmodule

`default_nettype wire
